// ===== hw/rtl/sarl_pkg.sv =====
// ----------------------------------------------------------------------------
// sarl_pkg
// Types and constants for the per-source rate limiter.
// ----------------------------------------------------------------------------
package sarl_pkg;

  localparam int unsigned TableEntries = 65536;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned SumW         = 19;   // eight 16-bit words
  localparam int unsigned NumWords     = 8;

  localparam logic [15:0] LimitReset   = 16'd6;
  localparam logic [15:0] HashModulus  = 16'hffff;

  // IPv4 / IPv6 prefixes that mask
  localparam logic [5:0] V4Pfx8  = 6'd8;
  localparam logic [5:0] V4Pfx16 = 6'd16;
  localparam logic [5:0] V4Pfx24 = 6'd24;
  localparam logic [7:0] V6Pfx32 = 8'd32;
  localparam logic [7:0] V6Pfx64 = 8'd64;

  localparam logic CmdCheck = 1'b0;
  localparam logic CmdAdd   = 1'b1;

  typedef enum logic [1:0] {
    REG_LIMIT = 2'd0,
    REG_V4PFX = 2'd1,
    REG_V6PFX = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_FOLD  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_UPD   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [15:0] stamp;
    logic [15:0] count;
  } entry_t;

endpackage

// ===== hw/rtl/source_address_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// source_address_rate_limiter
// Hashed fixed-window rate limiter: 64K-entry table of {second, count}.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  input     in_*                          start & !busy
//  result    out_*                         out_valid, one cycle, no stall
//  config    psel penable pwrite paddr ..  APB, pready tied high
//
//  An item passes mask+sum, mod fold, table read (sync RAM), update/write
//  and the output register between accept and result strobe.
//  A new item is accepted only once the last one is in update/write; the
//  single table read-modify-write port sets that.
//  After reset the table is cleared, one entry a cycle, with busy high until
//  all 65536 entries are zero. Config writes are taken at any time.
// ----------------------------------------------------------------------------
module source_address_rate_limiter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic        in_is_ipv6,
  input  logic [63:0] in_address_high,
  input  logic [63:0] in_address_low,
  input  logic [15:0] in_now_second,
  // result channel
  output logic        out_valid,
  output logic        out_limited,
  output logic [15:0] out_bucket,
  output logic [15:0] out_entry_count,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sarl_pkg::state_t state_r, state_nxt;

  logic [15:0] limit_r;
  logic [5:0]  v4pfx_r;
  logic [7:0]  v6pfx_r;

  logic                      cmd_r;
  logic                      v6_r;
  logic [127:0]              addr_r;
  logic [15:0]               now_r;
  logic [sarl_pkg::SumW-1:0] sum_r;
  logic [sarl_pkg::IdxW-1:0] bucket_r;
  logic [sarl_pkg::IdxW-1:0] clr_addr_r;
  sarl_pkg::entry_t          rd_q_r;

  logic        out_valid_r;
  logic        out_limited_r;
  logic [15:0] out_bucket_r;
  logic [15:0] out_count_r;

  logic accept;
  logic cfg_wr;
  sarl_pkg::reg_idx_t reg_idx;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = sarl_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sarl_pkg::LimitReset;
      v4pfx_r <= '0;
      v6pfx_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sarl_pkg::REG_LIMIT: limit_r <= pwdata[15:0];
        sarl_pkg::REG_V4PFX: v4pfx_r <= pwdata[5:0];
        sarl_pkg::REG_V6PFX: v6pfx_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sarl_pkg::REG_LIMIT: prdata = {16'd0, limit_r};
      sarl_pkg::REG_V4PFX: prdata = {26'd0, v4pfx_r};
      sarl_pkg::REG_V6PFX: prdata = {24'd0, v6pfx_r};
      default:             prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  assign busy   = !((state_r == sarl_pkg::ST_IDLE) || (state_r == sarl_pkg::ST_UPD));
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sarl_pkg::ST_CLEAR: if (clr_addr_r == '1) state_nxt = sarl_pkg::ST_IDLE;
      sarl_pkg::ST_IDLE:  if (accept) state_nxt = sarl_pkg::ST_HASH;
      sarl_pkg::ST_HASH:  state_nxt = sarl_pkg::ST_FOLD;
      sarl_pkg::ST_FOLD:  state_nxt = sarl_pkg::ST_READ;
      sarl_pkg::ST_READ:  state_nxt = sarl_pkg::ST_UPD;
      sarl_pkg::ST_UPD:   state_nxt = accept ? sarl_pkg::ST_HASH : sarl_pkg::ST_IDLE;
      default:            state_nxt = sarl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sarl_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sarl_pkg::ST_CLEAR) clr_addr_r <= clr_addr_r + sarl_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      v6_r   <= in_is_ipv6;
      addr_r <= {in_address_high, in_address_low};
      now_r  <= in_now_second;
    end
  end

  // ---------------- hash: mask and word sum ----------------
  logic [4:0]                keep;
  logic [15:0]               byte_keep;
  logic [sarl_pkg::SumW-1:0] sum_nxt;

  always_comb begin
    if (v6_r) begin
      if (v6pfx_r == sarl_pkg::V6Pfx32)      keep = 5'd4;
      else if (v6pfx_r == sarl_pkg::V6Pfx64) keep = 5'd8;
      else                                   keep = 5'd16;
    end else begin
      if (v4pfx_r == sarl_pkg::V4Pfx8)       keep = 5'd1;
      else if (v4pfx_r == sarl_pkg::V4Pfx16) keep = 5'd2;
      else if (v4pfx_r == sarl_pkg::V4Pfx24) keep = 5'd3;
      else                                   keep = 5'd4;
    end
    for (int i = 0; i < 16; i++) begin
      byte_keep[i] = (5'(i) < keep);
    end
  end

  // word k = byte[2k] | byte[2k+1] << 8; byte i sits at addr_r[127-8i -: 8]
  always_comb begin
    logic [7:0] b_lo, b_hi;
    sum_nxt = '0;
    for (int k = 0; k < sarl_pkg::NumWords; k++) begin
      b_lo = byte_keep[2*k]   ? addr_r[127-16*k -: 8]     : 8'd0;
      b_hi = byte_keep[2*k+1] ? addr_r[127-16*k-8 -: 8]   : 8'd0;
      sum_nxt = sum_nxt + sarl_pkg::SumW'({b_hi, b_lo});
    end
  end

  // mod 0xffff: 2^16 == 1, fold the top bits in, then one compare/subtract
  logic [16:0] fold;
  logic [15:0] bucket_nxt;

  always_comb begin
    fold = {1'b0, sum_r[15:0]} + 17'(sum_r[sarl_pkg::SumW-1:16]);
    if (fold >= {1'b0, sarl_pkg::HashModulus}) begin
      bucket_nxt = 16'(fold - {1'b0, sarl_pkg::HashModulus});
    end else begin
      bucket_nxt = fold[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sarl_pkg::ST_HASH) sum_r <= sum_nxt;
    if (state_r == sarl_pkg::ST_FOLD) bucket_r <= bucket_nxt;
  end

  // ---------------- table ----------------
  sarl_pkg::entry_t          tbl_mem [sarl_pkg::TableEntries];
  logic                      wr_en;
  logic [sarl_pkg::IdxW-1:0] wr_addr;
  sarl_pkg::entry_t          wr_data;
  logic                      same_sec;
  logic [15:0]               upd_count;

  assign same_sec  = (rd_q_r.stamp == now_r);
  assign upd_count = same_sec ? rd_q_r.count + 16'd1 : 16'd1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bucket_r;
    wr_data = '{stamp: now_r, count: upd_count};
    if (state_r == sarl_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (state_r == sarl_pkg::ST_UPD && cmd_r == sarl_pkg::CmdAdd) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (state_r == sarl_pkg::ST_READ) rd_q_r <= tbl_mem[bucket_r];
  end

  // ---------------- result ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == sarl_pkg::ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sarl_pkg::ST_UPD) begin
      out_bucket_r <= bucket_r;
      if (cmd_r == sarl_pkg::CmdAdd) begin
        out_limited_r <= 1'b0;
        out_count_r   <= upd_count;
      end else begin
        out_limited_r <= same_sec && (rd_q_r.count >= limit_r);
        out_count_r   <= rd_q_r.count;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_limited     = out_limited_r;
  assign out_bucket      = out_bucket_r;
  assign out_entry_count = out_count_r;

`ifndef NO_ASSERTIONS
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("result strobe missing after accepted item");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == sarl_pkg::ST_UPD))
    else $error("result strobe without update cycle");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bucket != 16'hffff))
    else $error("bucket out of hash range");

  a_limited_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limited) |-> (out_entry_count >= limit_r))
    else $error("limited reported below limit");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sarl_pkg::ST_CLEAR) |=> !out_valid)
    else $error("result during table clear");
`endif

endmodule

// ===== tb/tb_source_address_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// tb_source_address_rate_limiter
// Self-checking bench for the per-source rate limiter. Items go in through the
// start/busy handshake. Each result strobe is compared with the oldest verdict
// pending, predicted by an in-bench copy of the bucket table or typed into a
// directed row. Prefixes and limit are changed over APB between phases, while
// the block is idle. The bench runs a directed table, one same-second add run
// that climbs past the limit, and randomized phases from a small source pool.
// ----------------------------------------------------------------------------
module tb_source_address_rate_limiter;

  typedef struct packed {
    logic        command;
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] now_sec;
  } src_item_t;

  typedef struct packed {
    logic        limited;
    logic [15:0] bucket;
    logic [15:0] count;
  } verdict_t;

  typedef struct packed {
    src_item_t item;
    logic      typed;   // known verdict below is used instead of the prediction
    verdict_t  known;
  } dir_row_t;

  localparam int unsigned NumDirRows = 17;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned PoolSize   = 8;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned RunItems   = 40;
  localparam logic [15:0] RunLimit   = 16'd32;
  localparam logic [63:0] Ones       = 64'hffff_ffff_ffff_ffff;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{'{sarl_pkg::CmdCheck, 1'b0, 64'h0, 64'h0, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdCheck, 1'b0, Ones, Ones, 16'h0000},   1'b1, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdAdd, 1'b1, Ones, Ones, 16'hffff},     1'b1, '{1'b0, 16'h0000, 16'd1}},
    '{'{sarl_pkg::CmdCheck, 1'b1, 64'h0, 64'h0, 16'hffff}, 1'b1, '{1'b0, 16'h0000, 16'd1}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h0, Ones, 16'hffff},    1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h0000_0000_ffff_ffff, 64'h0, 16'hffff},
      1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h0, 64'h0, 16'hffff},   1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdAdd, 1'b1, 64'h0, 64'h0, 16'hffff},   1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h0, 64'h0, 16'hffff},   1'b0, '{1'b0, 16'h0000, 16'd0}},
    // bucket 0 now holds six packets in second ffff: at the reset limit
    '{'{sarl_pkg::CmdCheck, 1'b0, 64'h0, 64'h0, 16'hffff}, 1'b1, '{1'b1, 16'h0000, 16'd6}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h0, 64'h0, 16'h0000},   1'b1, '{1'b0, 16'h0000, 16'd1}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h0102_0304_dead_beef, 64'h0123_4567_89ab_cdef,
        16'h0007},
      1'b1, '{1'b0, 16'h0604, 16'd1}},
    '{'{sarl_pkg::CmdCheck, 1'b0, 64'h0102_0304_0000_0000, 64'h0, 16'h0007},
      1'b1, '{1'b0, 16'h0604, 16'd1}},
    '{'{sarl_pkg::CmdAdd, 1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        16'h8000},
      1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdCheck, 1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        16'h8000},
      1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdCheck, 1'b0, 64'hffff_fffe_0000_0000, Ones, 16'h0001},
      1'b0, '{1'b0, 16'h0000, 16'd0}},
    '{'{sarl_pkg::CmdAdd, 1'b0, 64'h8000_0000_ffff_ffff, 64'h0, 16'h0001},
      1'b0, '{1'b0, 16'h0000, 16'd0}}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic        in_is_ipv6;
  logic [63:0] in_address_high;
  logic [63:0] in_address_low;
  logic [15:0] in_now_second;
  logic        out_valid;
  logic        out_limited;
  logic [15:0] out_bucket;
  logic [15:0] out_entry_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  source_address_rate_limiter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_is_ipv6      (in_is_ipv6),
    .in_address_high (in_address_high),
    .in_address_low  (in_address_low),
    .in_now_second   (in_now_second),
    .out_valid       (out_valid),
    .out_limited     (out_limited),
    .out_bucket      (out_bucket),
    .out_entry_count (out_entry_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // bench copy of the bucket table and registers
  bit   [15:0] stamp_tbl [sarl_pkg::TableEntries];
  bit   [15:0] count_tbl [sarl_pkg::TableEntries];
  logic [15:0] limit_cfg  = sarl_pkg::LimitReset;
  logic [5:0]  v4_pfx_cfg = '0;
  logic [7:0]  v6_pfx_cfg = '0;

  verdict_t    pending_verdicts [$];
  verdict_t    oldest;
  int unsigned mismatches = 0;

  src_item_t   src_pool [PoolSize];
  logic [15:0] cur_sec;
  int unsigned burst_left = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Masks the address to its prefix, hashes it, and applies the command to
  // the bench table. Returns the verdict the block should report.
  function automatic verdict_t rate_verdict(input src_item_t it);
    logic [7:0]  addr_byte [16];
    int unsigned keep;
    int unsigned nwords;
    int unsigned sum;
    logic [15:0] idx;
    verdict_t    v;
    for (int i = 0; i < 8; i++) begin
      addr_byte[i]     = it.addr_hi[63-8*i -: 8];
      addr_byte[8 + i] = it.addr_lo[63-8*i -: 8];
    end
    if (it.is_ipv6) begin
      nwords = 8;
      keep   = 16;
      if (v6_pfx_cfg == sarl_pkg::V6Pfx32) keep = 4;
      else if (v6_pfx_cfg == sarl_pkg::V6Pfx64) keep = 8;
    end else begin
      nwords = 2;
      keep   = 4;
      if (v4_pfx_cfg == sarl_pkg::V4Pfx8) keep = 1;
      else if (v4_pfx_cfg == sarl_pkg::V4Pfx16) keep = 2;
      else if (v4_pfx_cfg == sarl_pkg::V4Pfx24) keep = 3;
    end
    for (int i = 0; i < 16; i++) begin
      if (i >= keep) addr_byte[i] = 8'h00;
    end
    sum = 0;
    for (int k = 0; k < nwords; k++) begin
      sum += {16'h0000, addr_byte[2*k+1], addr_byte[2*k]};
    end
    idx       = 16'(sum % {16'h0000, sarl_pkg::HashModulus});
    v.limited = 1'b0;
    v.bucket  = idx;
    if (it.command == sarl_pkg::CmdAdd) begin
      if (stamp_tbl[idx] != it.now_sec) begin
        stamp_tbl[idx] = it.now_sec;
        count_tbl[idx] = 16'd1;
      end else begin
        count_tbl[idx] = count_tbl[idx] + 16'd1;   // wraps at 16 bits
      end
    end else begin
      v.limited = (stamp_tbl[idx] == it.now_sec) && (count_tbl[idx] >= limit_cfg);
    end
    v.count = count_tbl[idx];
    return v;
  endfunction

  // Holds start low for the given gap, then offers the item until busy is sampled low and the block takes it.
  // With no gap, start stays high from the previous item.
  task automatic issue(input src_item_t it, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= it.command;
    in_is_ipv6      <= it.is_ipv6;
    in_address_high <= it.addr_hi;
    in_address_low  <= it.addr_lo;
    in_now_second   <= it.now_sec;
    do @(posedge clk); while (busy);
  endtask

  task automatic apb_write(input sarl_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sarl_pkg::REG_LIMIT: limit_cfg  = val[15:0];
      sarl_pkg::REG_V4PFX: v4_pfx_cfg = val[5:0];
      sarl_pkg::REG_V6PFX: v6_pfx_cfg = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // all results in, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  function automatic int unsigned draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 30);
    return $urandom_range(0, 16);
  endfunction

  // Mostly traffic from the pool in the current second, so buckets fill up;
  // the rest is fully random noise.
  function automatic src_item_t draw_item();
    src_item_t it;
    if ($urandom_range(0, 99) < 85) begin
      it = src_pool[$urandom_range(0, PoolSize - 1)];
      case ($urandom_range(0, 2))
        1: begin
          // bytes 3 and up change: same group under the shorter prefixes
          it.addr_hi[39:0] = {8'($urandom), $urandom};
          it.addr_lo       = {$urandom, $urandom};
        end
        2: it.addr_lo = {$urandom, $urandom};
        default: ;
      endcase
      it.command = ($urandom_range(0, 99) < 60) ? sarl_pkg::CmdAdd : sarl_pkg::CmdCheck;
      if ($urandom_range(0, 39) == 0) cur_sec = cur_sec + 16'd1;
      else if ($urandom_range(0, 199) == 0) cur_sec = 16'($urandom);
      it.now_sec = cur_sec;
    end else begin
      it.command = $urandom_range(0, 1) ? sarl_pkg::CmdAdd : sarl_pkg::CmdCheck;
      it.is_ipv6 = 1'($urandom_range(0, 1));
      it.addr_hi = {$urandom, $urandom};
      it.addr_lo = {$urandom, $urandom};
      it.now_sec = 16'($urandom);
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $error("result strobe with no item outstanding");
      end else begin
        oldest = pending_verdicts.pop_front();
        if (out_limited !== oldest.limited) begin
          mismatches++;
          $error("limited: expected %0d, got %0d", oldest.limited, out_limited);
        end
        if (out_bucket !== oldest.bucket) begin
          mismatches++;
          $error("bucket: expected %0h, got %0h", oldest.bucket, out_bucket);
        end
        if (out_entry_count !== oldest.count) begin
          mismatches++;
          $error("entry_count: expected %0d, got %0d", oldest.count, out_entry_count);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("source_address_rate_limiter: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] ph_limit [NumPhases];
    logic [5:0]  ph_v4    [NumPhases];
    logic [7:0]  ph_v6    [NumPhases];
    src_item_t   it;
    verdict_t    v;

    ph_limit = '{16'd0, 16'd1, 16'd3, 16'd4, 16'd6, 16'hffff};
    ph_v4    = '{6'd8, 6'd16, 6'd24, 6'd0, 6'd32, 6'd0};
    ph_v6    = '{8'd32, 8'd64, 8'd0, 8'd0, 8'd128, 8'd63};

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_command      <= sarl_pkg::CmdCheck;
    in_is_ipv6      <= 1'b0;
    in_address_high <= '0;
    in_address_low  <= '0;
    in_now_second   <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows run on reset settings; the first one waits out the clear
    for (int i = 0; i < NumDirRows; i++) begin
      issue(DirRows[i].item, $urandom_range(0, 16));
      v = rate_verdict(DirRows[i].item);
      if (DirRows[i].typed) v = DirRows[i].known;
      pending_verdicts.push_back(v);
    end

    // one source, one second, back to back: the count climbs past the limit,
    // with a check right when it reaches it
    drain();
    apb_write(sarl_pkg::REG_LIMIT, {16'h0000, RunLimit});
    it = '{sarl_pkg::CmdAdd, 1'b0, 64'hc0a8_0101_0000_0000, 64'h0, 16'h4242};
    for (int unsigned n = 0; n < RunItems; n++) begin
      it.command = (n == RunLimit) ? sarl_pkg::CmdCheck : sarl_pkg::CmdAdd;
      issue(it, 0);
      pending_verdicts.push_back(rate_verdict(it));
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p == 3) begin
        ph_limit[p] = 16'($urandom_range(2, 12));
        ph_v4[p]    = 6'($urandom_range(0, 32));
        ph_v6[p]    = 8'($urandom_range(0, 128));
      end
      apb_write(sarl_pkg::REG_LIMIT, {16'h0000, ph_limit[p]});
      apb_write(sarl_pkg::REG_V4PFX, {26'h0, ph_v4[p]});
      apb_write(sarl_pkg::REG_V6PFX, {24'h0, ph_v6[p]});
      apb_write(sarl_pkg::REG_NONE, $urandom);   // no such register: ignored
      for (int k = 0; k < PoolSize; k++) begin
        src_pool[k] = '{sarl_pkg::CmdAdd, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                        {$urandom, $urandom}, 16'h0000};
      end
      cur_sec = 16'($urandom);
      for (int n = 0; n < PhaseItems; n++) begin
        it = draw_item();
        issue(it, draw_gap());
        pending_verdicts.push_back(rate_verdict(it));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("source_address_rate_limiter: match");
    end else begin
      $display("source_address_rate_limiter: mismatch");
    end
    $finish;
  end

endmodule
